>>> hw/rtl/fla_pkg.sv
`default_nettype none

package fla_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = IDX_W + 1;

  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 11;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_DEPTH);

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SLOTS_RESET = CFG_DATA_W'(1024);

  typedef struct packed {
    logic                set_res;
    logic [STATUS_W-1:0] res_status;
    logic                refuse;
    logic                read_head;
    logic                pop;
    logic                push;
    logic                sweep_start;
    logic                sweep_write;
    logic                list_reset;
    logic                load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic closed;
    logic empty;
    logic slot_oor;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [LINK_W-1:0] eff_slots(input logic [CFG_DATA_W-1:0] v);
    logic [LINK_W-1:0] r;
    if (v == '0) begin
      r = LINK_W'(1);
    end else if (int'(v) > POOL_DEPTH) begin
      r = LINK_END;
    end else begin
      r = LINK_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fla_ram.sv
`default_nettype none

module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fla_ctrl.sv
`default_nettype none

module fla_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [fla_pkg::KIND_W-1:0]   in_kind_i,
  output logic                              in_stall_o,
  input  wire fla_pkg::dp_sts_t             sts_i,
  output fla_pkg::dp_cmd_t                  cmd_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_write = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.list_reset = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            fla_pkg::KIND_ALLOC: begin
              if (sts_i.closed) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = fla_pkg::ST_CLOSED;
                cmd_o.refuse     = 1'b1;
                state_d          = S_EMIT;
              end else if (sts_i.empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = fla_pkg::ST_EXHAUSTED;
                state_d          = S_EMIT;
              end else begin
                cmd_o.read_head = 1'b1;
                state_d         = S_READ;
              end
            end
            fla_pkg::KIND_FREE: begin
              cmd_o.set_res = 1'b1;
              if (sts_i.slot_oor) begin
                cmd_o.res_status = fla_pkg::ST_RANGE;
              end else begin
                cmd_o.res_status = fla_pkg::ST_OK;
                cmd_o.push       = 1'b1;
              end
              state_d = S_EMIT;
            end
            fla_pkg::KIND_REINIT: begin
              cmd_o.set_res     = 1'b1;
              cmd_o.res_status  = fla_pkg::ST_OK;
              cmd_o.sweep_start = 1'b1;
              state_d           = S_SWEEP;
            end
            default: begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = fla_pkg::ST_OK;
              state_d          = S_EMIT;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.pop = 1'b1;
        state_d   = S_EMIT;
      end
      S_SWEEP: begin
        cmd_o.sweep_write = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.list_reset = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/fla_dp.sv
`default_nettype none

module fla_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [fla_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [fla_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [fla_pkg::SLOT_W-1:0]        in_slot_i,
  input  wire fla_pkg::dp_cmd_t                  cmd_i,
  output fla_pkg::dp_sts_t                       sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [fla_pkg::STATUS_W-1:0]           out_status_o,
  output logic [fla_pkg::SLOT_W-1:0]             out_granted_slot_o,
  output logic [fla_pkg::CNT_W-1:0]              out_allocated_now_o,
  output logic [fla_pkg::CNT_W-1:0]              out_available_now_o,
  output logic [fla_pkg::TOTAL_W-1:0]            out_allocations_total_o,
  output logic [fla_pkg::TOTAL_W-1:0]            out_frees_total_o,
  output logic [fla_pkg::TOTAL_W-1:0]            out_refusals_total_o
);

  logic [fla_pkg::CFG_DATA_W-1:0] slots_q;
  logic                           closed_q;
  logic [fla_pkg::LINK_W-1:0]     eff;

  logic [fla_pkg::LINK_W-1:0]     head_q, head_d;
  logic [fla_pkg::LINK_W-1:0]     count_q, count_d;
  logic [fla_pkg::TOTAL_W-1:0]    alloc_tot_q, alloc_tot_d;
  logic [fla_pkg::TOTAL_W-1:0]    free_tot_q, free_tot_d;
  logic [fla_pkg::TOTAL_W-1:0]    refuse_tot_q, refuse_tot_d;
  logic [fla_pkg::IDX_W-1:0]      sweep_q, sweep_d;
  logic [fla_pkg::IDX_W-1:0]      sweep_last_q, sweep_last_d;
  logic [fla_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [fla_pkg::SLOT_W-1:0]     res_granted_q, res_granted_d;

  logic                           out_valid_q, out_valid_d;
  logic [fla_pkg::STATUS_W-1:0]   out_status_q;
  logic [fla_pkg::SLOT_W-1:0]     out_granted_q;
  logic [fla_pkg::CNT_W-1:0]      out_alloc_now_q;
  logic [fla_pkg::CNT_W-1:0]      out_avail_now_q;
  logic [fla_pkg::TOTAL_W-1:0]    out_alloc_tot_q;
  logic [fla_pkg::TOTAL_W-1:0]    out_free_tot_q;
  logic [fla_pkg::TOTAL_W-1:0]    out_refuse_tot_q;
  logic [fla_pkg::LINK_W-1:0]     avail;

  logic                           mem_we;
  logic [fla_pkg::IDX_W-1:0]      mem_waddr;
  logic [fla_pkg::LINK_W-1:0]     mem_wdata;
  logic [fla_pkg::LINK_W-1:0]     mem_rdata;

  assign eff = fla_pkg::eff_slots(slots_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= fla_pkg::SLOTS_RESET;
      closed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fla_pkg::CFG_SLOTS:  slots_q  <= cfg_data_i;
        fla_pkg::CFG_CLOSED: closed_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign sts_o.closed     = closed_q;
  assign sts_o.empty      = (head_q >= fla_pkg::LINK_END);
  assign sts_o.slot_oor   = (int'(in_slot_i) >= int'(eff));
  assign sts_o.sweep_last = (sweep_q == sweep_last_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    alloc_tot_d   = alloc_tot_q;
    free_tot_d    = free_tot_q;
    refuse_tot_d  = refuse_tot_q;
    sweep_d       = sweep_q;
    sweep_last_d  = sweep_last_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    mem_we        = 1'b0;
    mem_waddr     = sweep_q;
    mem_wdata     = (sweep_q == sweep_last_q) ? fla_pkg::LINK_END
                                              : fla_pkg::LINK_W'(sweep_q) + 1'b1;

    if (cmd_i.set_res) begin
      res_status_d  = cmd_i.res_status;
      res_granted_d = '0;
    end
    if (cmd_i.refuse) begin
      refuse_tot_d = refuse_tot_q + 1'b1;
    end
    if (cmd_i.pop) begin
      res_status_d  = fla_pkg::ST_OK;
      res_granted_d = fla_pkg::SLOT_W'(head_q);
      head_d        = mem_rdata;
      if (count_q < fla_pkg::LINK_END) begin
        count_d = count_q + 1'b1;
      end
      alloc_tot_d = alloc_tot_q + 1'b1;
    end
    if (cmd_i.push) begin
      mem_we    = 1'b1;
      mem_waddr = fla_pkg::IDX_W'(in_slot_i);
      mem_wdata = head_q;
      head_d    = fla_pkg::LINK_W'(in_slot_i);
      if (count_q != '0) begin
        count_d = count_q - 1'b1;
      end
      free_tot_d = free_tot_q + 1'b1;
    end
    if (cmd_i.sweep_start) begin
      sweep_d      = '0;
      sweep_last_d = fla_pkg::IDX_W'(eff - 1'b1);
    end
    if (cmd_i.sweep_write) begin
      mem_we  = 1'b1;
      sweep_d = sweep_q + 1'b1;
    end
    if (cmd_i.list_reset) begin
      head_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      count_q       <= '0;
      alloc_tot_q   <= '0;
      free_tot_q    <= '0;
      refuse_tot_q  <= '0;
      sweep_q       <= '0;
      sweep_last_q  <= fla_pkg::IDX_W'(fla_pkg::POOL_DEPTH - 1);
      res_status_q  <= fla_pkg::ST_OK;
      res_granted_q <= '0;
    end else begin
      head_q        <= head_d;
      count_q       <= count_d;
      alloc_tot_q   <= alloc_tot_d;
      free_tot_q    <= free_tot_d;
      refuse_tot_q  <= refuse_tot_d;
      sweep_q       <= sweep_d;
      sweep_last_q  <= sweep_last_d;
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
    end
  end

  fla_ram #(
    .WIDTH (fla_pkg::LINK_W),
    .DEPTH (fla_pkg::POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.read_head),
    .raddr_i (fla_pkg::IDX_W'(head_q)),
    .rdata_o (mem_rdata)
  );

  assign avail = (eff > count_q) ? (eff - count_q) : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q     <= res_status_q;
      out_granted_q    <= res_granted_q;
      out_alloc_now_q  <= fla_pkg::CNT_W'(count_q);
      out_avail_now_q  <= fla_pkg::CNT_W'(avail);
      out_alloc_tot_q  <= alloc_tot_q;
      out_free_tot_q   <= free_tot_q;
      out_refuse_tot_q <= refuse_tot_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_status_o            = out_status_q;
  assign out_granted_slot_o      = out_granted_q;
  assign out_allocated_now_o     = out_alloc_now_q;
  assign out_available_now_o     = out_avail_now_q;
  assign out_allocations_total_o = out_alloc_tot_q;
  assign out_frees_total_o       = out_free_tot_q;
  assign out_refusals_total_o    = out_refuse_tot_q;

endmodule

`default_nettype wire

>>> hw/rtl/free_list_slot_allocator.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    kind, slot
// out      output     out_valid_o / out_stall_i  status, granted_slot, counts, totals
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time. Free, refused or empty allocate and unused kinds go from idle to emit;
// a successful allocate passes through the read state, set by the registered read of the link RAM.
// Reinitialize passes through the sweep state, one link RAM write per slot of the clamped count.
// After reset the link RAM is built by a pass over all POOL_DEPTH (1024) entries before any beat
// is accepted; configuration writes are taken throughout.
// A result waiting in the output register does not block the next input beat.
`default_nettype none

module free_list_slot_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [fla_pkg::KIND_W-1:0]      in_kind_i,
  input  wire logic [fla_pkg::SLOT_W-1:0]      in_slot_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [fla_pkg::STATUS_W-1:0]         out_status_o,
  output logic [fla_pkg::SLOT_W-1:0]           out_granted_slot_o,
  output logic [fla_pkg::CNT_W-1:0]            out_allocated_now_o,
  output logic [fla_pkg::CNT_W-1:0]            out_available_now_o,
  output logic [fla_pkg::TOTAL_W-1:0]          out_allocations_total_o,
  output logic [fla_pkg::TOTAL_W-1:0]          out_frees_total_o,
  output logic [fla_pkg::TOTAL_W-1:0]          out_refusals_total_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fla_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  fla_pkg::dp_cmd_t cmd;
  fla_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fla_dp u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .in_slot_i               (in_slot_i),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_status_o            (out_status_o),
    .out_granted_slot_o      (out_granted_slot_o),
    .out_allocated_now_o     (out_allocated_now_o),
    .out_available_now_o     (out_available_now_o),
    .out_allocations_total_o (out_allocations_total_o),
    .out_frees_total_o       (out_frees_total_o),
    .out_refusals_total_o    (out_refusals_total_o)
  );

endmodule

`default_nettype wire
